// ===== hdl/hcic_pkg.sv =====
// ----------------------------------------------------------------------------
// hcic_pkg: shared definitions for the Hilbert curve index codec
// Operation codes, configuration defaults and the per-cell control struct.
// ----------------------------------------------------------------------------
package hcic_pkg;

  // configuration register width and reset value
  localparam int unsigned ORDER_W       = 6;
  localparam logic [5:0]  ORDER_RESET   = 6'd16;

  // default and largest supported curve order (bits per coordinate)
  localparam int unsigned MAX_ORDER_DEF = 32;

  // fixed port widths
  localparam int unsigned COORD_W       = 32;
  localparam int unsigned INDEX_W       = 64;

  // operation codes
  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // control bits that travel with each request down the chain
  typedef struct packed {
    logic valid;  // request present in this cell
    logic op;     // OP_ENCODE or OP_DECODE
    logic ok;     // coordinates were inside the grid
  } hcic_ctl_t;

endpackage

// ===== hdl/hcic_cell.sv =====
// ----------------------------------------------------------------------------
// hcic_cell: one level of the Hilbert codec chain
// Encode handles coordinate bit MAX_ORDER-1-POS, decode handles bit POS.
// Levels at or above the active order pass the request through unchanged.
// ----------------------------------------------------------------------------
module hcic_cell #(
  parameter int unsigned MAX_ORDER = hcic_pkg::MAX_ORDER_DEF,
  parameter int unsigned POS       = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [hcic_pkg::ORDER_W-1:0] order,
  input  hcic_pkg::hcic_ctl_t        ctl_i,
  input  logic [MAX_ORDER-1:0]       x_i,
  input  logic [MAX_ORDER-1:0]       y_i,
  input  logic [2*MAX_ORDER-1:0]     idx_i,
  output hcic_pkg::hcic_ctl_t        ctl_o,
  output logic [MAX_ORDER-1:0]       x_o,
  output logic [MAX_ORDER-1:0]       y_o,
  output logic [2*MAX_ORDER-1:0]     idx_o
);

  // level handled in each direction
  localparam int unsigned LE = MAX_ORDER - 1 - POS;
  localparam int unsigned LD = POS;

  // masks of the bits below each level
  localparam logic [MAX_ORDER-1:0] MASK_E = {MAX_ORDER{1'b1}} >> (MAX_ORDER - LE);
  localparam logic [MAX_ORDER-1:0] MASK_D = {MAX_ORDER{1'b1}} >> (MAX_ORDER - LD);

  localparam logic [hcic_pkg::ORDER_W:0] LE_V = (hcic_pkg::ORDER_W+1)'(LE);
  localparam logic [hcic_pkg::ORDER_W:0] LD_V = (hcic_pkg::ORDER_W+1)'(LD);

  hcic_pkg::hcic_ctl_t    ctl_r;
  logic [MAX_ORDER-1:0]   x_r, y_r, x_nxt, y_nxt;
  logic [2*MAX_ORDER-1:0] idx_r, idx_nxt;
  logic                   rx, ry;
  logic [MAX_ORDER-1:0]   xt, yt;

  // level step: digit emit (encode) or bit insert (decode) with rotation
  always_comb begin
    x_nxt   = x_i;
    y_nxt   = y_i;
    idx_nxt = idx_i;
    rx      = 1'b0;
    ry      = 1'b0;
    xt      = x_i;
    yt      = y_i;
    if (ctl_i.op == hcic_pkg::OP_ENCODE) begin
      if (LE_V < {1'b0, order}) begin
        rx = x_i[LE];
        ry = y_i[LE];
        idx_nxt[2*LE+1] = ry;
        idx_nxt[2*LE]   = rx ^ ry;
        if (!rx) begin
          if (ry) begin
            xt = ~x_i & MASK_E;
            yt = ~y_i & MASK_E;
          end
          x_nxt = yt;
          y_nxt = xt;
        end
      end
    end else begin
      if (LD_V < {1'b0, order}) begin
        ry = idx_i[2*LD+1];
        rx = idx_i[2*LD] ^ ry;
        if (!rx) begin
          if (ry) begin
            xt = ~x_i & MASK_D;
            yt = ~y_i & MASK_D;
          end
          x_nxt = yt;
          y_nxt = xt;
        end
        // partial coordinates stay below this level, so adding is a bit set
        x_nxt[LD] = rx;
        y_nxt[LD] = ry;
      end
    end
  end

  // control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    idx_r <= idx_nxt;
  end

  assign ctl_o = ctl_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign idx_o = idx_r;

endmodule

// ===== hdl/hilbert_curve_index_codec.sv =====
// ----------------------------------------------------------------------------
// Each accepted request is registered in all MAX_ORDER level cells before its out_valid strobe.
// Throughput: one request per cycle; busy is never asserted, the chain of
// MAX_ORDER level cells moves every cycle and each cell handles one level.
// Reset: synchronous active-low; clears in-flight requests, order returns to 16.
// Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// hilbert_curve_index_codec: 2-D Hilbert curve encoder/decoder
// Converts (x, y) to a Hilbert index or back, for a configurable curve order.
// ----------------------------------------------------------------------------
module hilbert_curve_index_codec #(
  parameter int unsigned MAX_ORDER = hcic_pkg::MAX_ORDER_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_operation,
  input  logic [hcic_pkg::COORD_W-1:0]  in_coord_x,
  input  logic [hcic_pkg::COORD_W-1:0]  in_coord_y,
  input  logic [hcic_pkg::INDEX_W-1:0]  in_curve_index,
  // result channel
  output logic                          out_valid,
  output logic [hcic_pkg::INDEX_W-1:0]  out_result_index,
  output logic [hcic_pkg::COORD_W-1:0]  out_result_x,
  output logic [hcic_pkg::COORD_W-1:0]  out_result_y,
  output logic                          out_in_range,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hcic_pkg::ORDER_W-1:0]  cfg_data
);

  localparam logic [hcic_pkg::ORDER_W-1:0] MAX_ORDER_V = hcic_pkg::ORDER_W'(MAX_ORDER);
  localparam logic [hcic_pkg::ORDER_W-1:0] ONE_V       = hcic_pkg::ORDER_W'(1);

  logic [hcic_pkg::ORDER_W-1:0] order_r, order_eff;
  logic                         x_hi, y_hi;

  hcic_pkg::hcic_ctl_t    ctl_c [0:MAX_ORDER];
  logic [MAX_ORDER-1:0]   x_c   [0:MAX_ORDER];
  logic [MAX_ORDER-1:0]   y_c   [0:MAX_ORDER];
  logic [2*MAX_ORDER-1:0] idx_c [0:MAX_ORDER];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // curve order register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= hcic_pkg::ORDER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      order_r <= cfg_data;
    end
  end

  // clamp order to 1..MAX_ORDER
  always_comb begin
    if (order_r < ONE_V) begin
      order_eff = ONE_V;
    end else if (order_r > MAX_ORDER_V) begin
      order_eff = MAX_ORDER_V;
    end else begin
      order_eff = order_r;
    end
  end

  // grid range check and chain entry
  assign x_hi = (in_coord_x >> order_eff) != '0;
  assign y_hi = (in_coord_y >> order_eff) != '0;

  always_comb begin
    ctl_c[0].valid = start && !busy;
    ctl_c[0].op    = in_operation;
    ctl_c[0].ok    = (in_operation == hcic_pkg::OP_DECODE) || !(x_hi || y_hi);
    x_c[0]   = '0;
    y_c[0]   = '0;
    idx_c[0] = '0;
    if (in_operation == hcic_pkg::OP_DECODE) begin
      idx_c[0] = in_curve_index[2*MAX_ORDER-1:0];
    end else if (!(x_hi || y_hi)) begin
      x_c[0] = in_coord_x[MAX_ORDER-1:0];
      y_c[0] = in_coord_y[MAX_ORDER-1:0];
    end
  end

  // chain of level cells
  for (genvar g = 0; g < MAX_ORDER; g++) begin : g_cell
    hcic_cell #(
      .MAX_ORDER (MAX_ORDER),
      .POS       (g)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .order (order_eff),
      .ctl_i (ctl_c[g]),
      .x_i   (x_c[g]),
      .y_i   (y_c[g]),
      .idx_i (idx_c[g]),
      .ctl_o (ctl_c[g+1]),
      .x_o   (x_c[g+1]),
      .y_o   (y_c[g+1]),
      .idx_o (idx_c[g+1])
    );
  end

  // result formatting
  always_comb begin
    out_valid        = ctl_c[MAX_ORDER].valid;
    out_in_range     = ctl_c[MAX_ORDER].ok;
    out_result_index = '0;
    out_result_x     = '0;
    out_result_y     = '0;
    if (ctl_c[MAX_ORDER].op == hcic_pkg::OP_DECODE) begin
      out_result_x = hcic_pkg::COORD_W'(x_c[MAX_ORDER]);
      out_result_y = hcic_pkg::COORD_W'(y_c[MAX_ORDER]);
    end else if (ctl_c[MAX_ORDER].ok) begin
      out_result_index = hcic_pkg::INDEX_W'(idx_c[MAX_ORDER]);
    end
  end

endmodule

// ===== hdl/hcic_checker.sv =====
// ----------------------------------------------------------------------------
// hcic_checker: port-level assertions for the Hilbert codec
// Checks fixed latency and the zeroing rules of the result fields.
// ----------------------------------------------------------------------------
module hcic_checker #(
  parameter int unsigned MAX_ORDER = hcic_pkg::MAX_ORDER_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         in_operation,
  input logic                         out_valid,
  input logic [hcic_pkg::INDEX_W-1:0] out_result_index,
  input logic [hcic_pkg::COORD_W-1:0] out_result_x,
  input logic [hcic_pkg::COORD_W-1:0] out_result_y,
  input logic                         out_in_range
);

  localparam int unsigned CNT_W = $clog2(MAX_ORDER + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ORDER);

  // cycles since reset, saturating at the chain length
  logic [CNT_W-1:0] cnt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cnt_r != CNT_FULL) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // every accepted request comes out after passing through the MAX_ORDER cell registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == CNT_FULL) |-> (out_valid == $past(start && !busy, MAX_ORDER)))
    else $error("result strobe does not match request latency");

  // out-of-range result carries all zero fields
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_in_range) |->
      (out_result_index == '0 && out_result_x == '0 && out_result_y == '0))
    else $error("out-of-range result has nonzero fields");

  // only encode requests can be out of range
  a_oor_encode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_in_range && cnt_r == CNT_FULL) |->
      ($past(in_operation, MAX_ORDER) == hcic_pkg::OP_ENCODE))
    else $error("decode result flagged out of range");

  // a nonzero index never comes with decoded coordinates
  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_index != '0) |->
      (out_result_x == '0 && out_result_y == '0 && out_in_range))
    else $error("index and coordinates both present");

endmodule

bind hilbert_curve_index_codec hcic_checker #(
  .MAX_ORDER (MAX_ORDER)
) u_hcic_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_operation     (in_operation),
  .out_valid        (out_valid),
  .out_result_index (out_result_index),
  .out_result_x     (out_result_x),
  .out_result_y     (out_result_y),
  .out_in_range     (out_in_range)
);
